// File: rtl/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg
// shared types and constants for the byte run-length encoder
// ----------------------------------------------------------------------------
package brle_pkg;

  // largest repeat count a pair can carry (run of 256 bytes)
  localparam logic [7:0] RunMaxCount = 8'd255;

  // depth of the result queue and its index width
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueIdxW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // one encoded pair as it leaves the block
  typedef struct packed {
    logic [7:0] repeat_minus_one;
    logic [7:0] run_value;
    logic       row_last;
  } pair_t;

endpackage

// File: rtl/brle_if.sv
// ----------------------------------------------------------------------------
// brle_if
// valid/ready channels for raster bytes in and encoded pairs out
// ----------------------------------------------------------------------------
interface brle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       row_end;

  modport source (output valid, output data_byte, output row_end, input ready);
  modport sink   (input valid, input data_byte, input row_end, output ready);
endinterface

interface brle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] repeat_minus_one;
  logic [7:0] run_value;
  logic       row_last;

  modport source (output valid, output repeat_minus_one, output run_value,
                  output row_last, input ready);
  modport sink   (input valid, input repeat_minus_one, input run_value,
                  input row_last, output ready);
endinterface

// File: rtl/byte_run_length_encoder_unit.sv
// ----------------------------------------------------------------------------
// byte_run_length_encoder_unit
// each pair is registered into the result queue when its byte is taken, and out_o offers the queue head
// throughput: one byte per cycle while in_i.ready is high; a byte may cause up to two
//   pairs, and out_o moves one pair per beat through a four-entry result queue
// in_i.ready drops while the queue holds more than two pairs
// reset: no run pending, queue empty, out_o.valid low
// ----------------------------------------------------------------------------
module byte_run_length_encoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  brle_in_if.sink    in_i,
  brle_out_if.source out_o
);

  // current run
  logic [7:0] run_byte_q, run_byte_d;
  logic [7:0] run_count_q, run_count_d;
  logic       run_open_q, run_open_d;

  // result queue, plain register file addressed by read and write pointers
  brle_pkg::pair_t                     queue_mem [brle_pkg::QueueDepth];
  logic [brle_pkg::QueueIdxW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [brle_pkg::QueueIdxW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [brle_pkg::QueueCntW-1:0]      fill_q, fill_d;

  logic            in_beat, out_beat;
  logic            extend;
  logic            close_vld, flush_vld;
  logic [7:0]      next_byte, next_count;
  brle_pkg::pair_t close_pair, flush_pair;
  brle_pkg::pair_t slot0, slot1;
  logic [1:0]      push_cnt;
  logic [brle_pkg::QueueIdxW-1:0] wr_ptr_p1;

  // accept a byte only when room for two pairs is left
  assign in_i.ready = (fill_q <= brle_pkg::QueueCntW'(brle_pkg::QueueDepth - 2));
  assign in_beat    = in_i.valid & in_i.ready;

  assign out_o.valid = (fill_q != '0);
  assign out_beat    = out_o.valid & out_o.ready;

  // a byte compare, a full-run check and one increment decide the run update
  always_comb begin
    extend = run_open_q && (in_i.data_byte == run_byte_q) &&
             (run_count_q != brle_pkg::RunMaxCount);

    // a differing byte (or a full previous run) closes the pending run
    close_vld                   = run_open_q & ~extend;
    close_pair.repeat_minus_one = run_count_q;
    close_pair.run_value        = ~run_byte_q;
    close_pair.row_last         = 1'b0;

    if (extend) begin
      next_byte  = run_byte_q;
      next_count = run_count_q + 8'd1;
    end else begin
      next_byte  = in_i.data_byte;
      next_count = 8'd0;
    end

    // run hit 256 bytes or the row ended: flush right away
    flush_vld                   = (next_count == brle_pkg::RunMaxCount) | in_i.row_end;
    flush_pair.repeat_minus_one = next_count;
    flush_pair.run_value        = ~next_byte;
    flush_pair.row_last         = in_i.row_end;

    // keep order: close pair first, flush pair after it
    slot0    = close_vld ? close_pair : flush_pair;
    slot1    = flush_pair;
    push_cnt = 2'(close_vld) + 2'(flush_vld);
  end

  // next state for the run and the queue pointers
  always_comb begin
    run_byte_d  = run_byte_q;
    run_count_d = run_count_q;
    run_open_d  = run_open_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;

    if (in_beat) begin
      run_byte_d = next_byte;
      if (flush_vld) begin
        run_count_d = 8'd0;
        run_open_d  = 1'b0;
      end else begin
        run_count_d = next_count;
        run_open_d  = 1'b1;
      end
      wr_ptr_d = wr_ptr_q + brle_pkg::QueueIdxW'(push_cnt);
    end

    if (out_beat) begin
      rd_ptr_d = rd_ptr_q + brle_pkg::QueueIdxW'(1);
    end

    fill_d = fill_q
           + (in_beat ? brle_pkg::QueueCntW'(push_cnt) : '0)
           - brle_pkg::QueueCntW'(out_beat);
  end

  assign wr_ptr_p1 = wr_ptr_q + brle_pkg::QueueIdxW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_byte_q  <= 8'd0;
      run_count_q <= 8'd0;
      run_open_q  <= 1'b0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
    end else begin
      run_byte_q  <= run_byte_d;
      run_count_q <= run_count_d;
      run_open_q  <= run_open_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      fill_q      <= fill_d;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_beat && (push_cnt != 2'd0)) begin
      queue_mem[wr_ptr_q] <= slot0;
    end
    if (in_beat && (push_cnt == 2'd2)) begin
      queue_mem[wr_ptr_p1] <= slot1;
    end
  end

  // head of the queue drives the output beat
  assign out_o.repeat_minus_one = queue_mem[rd_ptr_q].repeat_minus_one;
  assign out_o.run_value        = queue_mem[rd_ptr_q].run_value;
  assign out_o.row_last         = queue_mem[rd_ptr_q].row_last;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for byte_run_length_encoder_unit: raster rows go in as
// valid/ready beats, every pair coming out is compared against a cycle-free
// run-length predictor, with random stalls on both sides
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one raster byte waiting to be sent, with an optional drain-first mark
  typedef struct {
    logic [7:0] data_byte;
    logic       row_end;
    bit         drain_first;
  } raster_beat_t;

  logic clk;
  logic rst_n;

  brle_in_if  in_if ();
  brle_out_if out_if ();

  byte_run_length_encoder_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // bytes still to be offered, pairs predicted but not yet seen
  raster_beat_t           raster_q[$];
  brle_pkg::pair_t        predicted_pairs[$];

  // predictor copy of the encoder run state
  logic [7:0] run_byte_m;
  logic [7:0] run_cnt_m;
  logic       run_open_m;

  int unsigned err_cnt;
  int unsigned beats_sent;
  int unsigned beats_taken;
  int unsigned hold_left;
  bit          hold_done;

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on pair %0d: %s got 0x%0h want 0x%0h",
             $time, beats_taken, what, got, want);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // predictor: folds one raster byte into the run and queues the pairs
  // it closes, the pair ended by a differing byte always first
  // --------------------------------------------------------------------------
  function automatic void encode_byte(input logic [7:0] b, input logic last);
    if (run_open_m && b == run_byte_m && run_cnt_m != brle_pkg::RunMaxCount) begin
      run_cnt_m = run_cnt_m + 8'd1;
    end else begin
      // a differing byte (or a full run just before) closes the old run
      if (run_open_m) begin
        predicted_pairs.push_back(brle_pkg::pair_t'{run_cnt_m, ~run_byte_m, 1'b0});
      end
      run_byte_m = b;
      run_cnt_m  = 8'd0;
      run_open_m = 1'b1;
    end
    // full run or row end flushes; at row end a full run goes out once
    if (run_cnt_m == brle_pkg::RunMaxCount || last) begin
      predicted_pairs.push_back(brle_pkg::pair_t'{run_cnt_m, ~run_byte_m, last});
      run_open_m = 1'b0;
      run_cnt_m  = 8'd0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus building
  // --------------------------------------------------------------------------
  task automatic push_run(input logic [7:0] b, input int len, input bit ends_row,
                          input bit drain_first);
    raster_beat_t rb;
    for (int i = 0; i < len; i++) begin
      rb.data_byte   = b;
      rb.row_end     = ends_row && (i == len - 1);
      rb.drain_first = drain_first && (i == 0);
      raster_q.push_back(rb);
    end
  endtask

  // a random row of short runs; long_kind 1 ends the row on a run of
  // exactly 256 bytes, long_kind 2 puts a run around 256 bytes up front
  task automatic add_random_row(input int long_kind, input bit drain_first);
    int         n_runs;
    int         len;
    int         r;
    logic [7:0] b;
    logic [7:0] prev;
    n_runs = $urandom_range(1, 6);
    prev   = 8'($urandom_range(0, 255));
    for (int k = 0; k < n_runs; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 3);
      else if (r < 95) len = $urandom_range(4, 12);
      else len = $urandom_range(13, 40);
      r = $urandom_range(0, 99);
      if (r < 60) b = 8'($urandom_range(0, 255));
      else if (r < 75) b = 8'h00;
      else if (r < 90) b = 8'hff;
      else b = prev;  // same byte again, runs merge
      if (long_kind == 2 && k == 0) len = $urandom_range(255, 258);
      if (long_kind == 1 && k == n_runs - 1) begin
        // differ from the run before so the row really ends on 256 bytes
        b   = prev ^ 8'($urandom_range(1, 255));
        len = 256;
      end
      push_run(b, len, k == n_runs - 1, drain_first && k == 0);
      prev = b;
    end
  endtask

  initial begin
    int row_idx;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.row_end   = 1'b0;
    out_if.ready    = 1'b0;
    run_byte_m      = 8'h00;
    run_cnt_m       = 8'h00;
    run_open_m      = 1'b0;
    err_cnt         = 0;
    beats_sent      = 0;
    beats_taken     = 0;
    hold_left       = 0;
    hold_done       = 0;

    // directed: zero bytes right after reset, where the stored byte is zero
    // but no run is open yet
    push_run(8'h00, 3, 1'b1, 1'b0);
    // single-byte rows at both byte extremes
    push_run(8'hff, 1, 1'b1, 1'b0);
    push_run(8'h00, 1, 1'b1, 1'b0);
    // a run closed by a differing byte that itself ends the row: two pairs
    push_run(8'haa, 3, 1'b0, 1'b0);
    push_run(8'h55, 1, 1'b1, 1'b0);
    // alternating bytes, every beat after the first closes a run
    push_run(8'h0f, 1, 1'b0, 1'b0);
    push_run(8'hf0, 1, 1'b0, 1'b0);
    push_run(8'h0f, 1, 1'b0, 1'b0);
    push_run(8'h80, 1, 1'b0, 1'b0);
    push_run(8'h01, 1, 1'b1, 1'b0);
    // a run ending the row, then the same byte opening the next row
    push_run(8'h7e, 4, 1'b1, 1'b0);
    push_run(8'h7e, 2, 1'b0, 1'b0);
    push_run(8'h81, 2, 1'b1, 1'b0);

    // random rows; the sender drains fully before the first and a later row
    row_idx = 0;
    while (raster_q.size() < 740) begin
      add_random_row(row_idx == 4 ? 1 : (row_idx == 9 ? 2 : 0),
                     row_idx == 0 || row_idx == 14);
      row_idx++;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // wait for all bytes to be taken and all pairs to come back
    while (raster_q.size() != 0 || in_if.valid) @(posedge clk);
    while (predicted_pairs.size() != 0) @(posedge clk);
    // trailing cycles to catch any stray pair
    repeat (10) @(posedge clk);

    if (err_cnt == 0) begin
      $display("** byte_run_length_encoder_unit: PASSED **");
    end else begin
      $display("** byte_run_length_encoder_unit: FAILED **");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // driver: offers raster beats from the queue, holds a beat until taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit calm;
    bit idle;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        encode_byte(in_if.data_byte, in_if.row_end);
        void'(raster_q.pop_front());
        beats_sent++;
      end
      calm = beats_sent >= 400 && beats_sent < 550;
      idle = !calm && $urandom_range(0, 99) < 21;
      if (in_if.valid && !in_if.ready) begin
        // beat still pending, keep it on the bus
      end else if (raster_q.size() == 0 || idle ||
                   (raster_q[0].drain_first && predicted_pairs.size() != 0)) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid     <= 1'b1;
        in_if.data_byte <= raster_q[0].data_byte;
        in_if.row_end   <= raster_q[0].row_end;
        raster_q[0].drain_first = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: takes pairs, checks them against the oldest prediction, and
  // holds off once for a long stretch so the result queue fills up
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    brle_pkg::pair_t want;
    bit              calm;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (predicted_pairs.size() == 0) begin
          report_mismatch("unexpected pair, repeat_minus_one",
                          out_if.repeat_minus_one, 0);
        end else begin
          want = predicted_pairs.pop_front();
          if (out_if.repeat_minus_one !== want.repeat_minus_one)
            report_mismatch("repeat_minus_one", out_if.repeat_minus_one,
                            want.repeat_minus_one);
          if (out_if.run_value !== want.run_value)
            report_mismatch("run_value", out_if.run_value, want.run_value);
          if (out_if.row_last !== want.row_last)
            report_mismatch("row_last", out_if.row_last, want.row_last);
        end
        beats_taken++;
      end
      // long hold-off, once, early in the random part
      if (!hold_done && beats_taken >= 40) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      calm = beats_taken >= 200 && beats_taken < 320;
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || $urandom_range(0, 99) >= 21;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  initial begin
    #2400000;
    $display("** byte_run_length_encoder_unit: FAILED **");
    $finish;
  end

endmodule

// File: byte_run_length_encoder_unit.f
rtl/brle_pkg.sv
rtl/brle_if.sv
rtl/byte_run_length_encoder_unit.sv
sim/tb.sv
